FILE: rtl/csd_pkg.sv
// Shared types and constants of the COBS stream decoder.
package csd_pkg;

    localparam int BYTE_W              = 8;
    localparam int DATA_W              = 32;
    localparam int PADDR_W             = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [BYTE_W-1:0] PAIR_MAX_CODE  = 8'd224;
    localparam logic [BYTE_W-1:0] PLAIN_MAX_CODE = 8'd255;

    // Register index, taken from paddr[PADDR_W-1:2]
    localparam logic [PADDR_W-3:0] REG_PAIR_MODE = 1'b0;

    // One queued command: the first result of an input byte, plus a flag
    // that asks for the two trailing zeros of a pair-mode block.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              frame_end;
        logic              tail_inlined;
        logic              pair_tail;
    } csd_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              frame_end;
        logic              tail_inlined;
        logic              last;
    } csd_res_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ZERO_A,
        PH_ZERO_B
    } csd_phase_t;

endpackage

FILE: rtl/csd_in_if.sv
// Coded byte channel: valid/ready handshake with one byte per beat.
interface csd_in_if;
    logic                      valid;
    logic                      ready;
    logic [csd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/csd_out_if.sv
// Decoded result channel: valid/ready handshake with one result per beat.
interface csd_out_if;
    logic                      valid;
    logic                      ready;
    logic [csd_pkg::BYTE_W-1:0] out_byte;
    logic                      has_byte;
    logic                      frame_end;
    logic                      tail_inlined;
    logic                      last;

    modport source (output valid, output out_byte, output has_byte, output frame_end,
                    output tail_inlined, output last, input ready);
    modport sink (input valid, input out_byte, input has_byte, input frame_end,
                  input tail_inlined, input last, output ready);
endinterface

FILE: rtl/csd_front.sv
// Front end: accepts coded bytes, tracks block state and queues commands.
module csd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_mode,
    csd_in_if.sink           coded,
    input  logic             queue_full,
    output logic             push,
    output csd_pkg::csd_cmd_t push_cmd
);
    import csd_pkg::*;

    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] block_code_reg, block_code_next;
    logic              zero_pending_reg, zero_pending_next;
    logic              accept;
    logic              emit;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] max_code;

    assign coded.ready = !queue_full;
    assign accept      = coded.valid && coded.ready;
    assign b           = coded.in_byte;
    assign max_code    = pair_mode ? PAIR_MAX_CODE : PLAIN_MAX_CODE;

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        block_code_next   = block_code_reg;
        zero_pending_next = zero_pending_reg;
        emit              = 1'b0;
        push_cmd          = '0;
        if (bytes_left_reg == '0)
        begin
            if (b == '0)
            begin
                // bare frame end; an owed zero is dropped
                emit               = 1'b1;
                push_cmd.frame_end = 1'b1;
                bytes_left_next    = '0;
                block_code_next    = '0;
                zero_pending_next  = 1'b0;
            end
            else
            begin
                emit              = zero_pending_reg;
                push_cmd.has_byte = 1'b1;
                block_code_next   = b;
                if (pair_mode && b > PAIR_MAX_CODE)
                    bytes_left_next = b - PAIR_MAX_CODE;
                else
                    bytes_left_next = b - 8'd1;
                zero_pending_next = (b < max_code);
            end
        end
        else if (b == '0)
        begin
            // zero inside a block: code byte stands in as the last data byte
            emit                  = 1'b1;
            push_cmd.data         = block_code_reg;
            push_cmd.has_byte     = 1'b1;
            push_cmd.frame_end    = 1'b1;
            push_cmd.tail_inlined = 1'b1;
            bytes_left_next       = '0;
            block_code_next       = '0;
            zero_pending_next     = 1'b0;
        end
        else
        begin
            emit               = 1'b1;
            push_cmd.data      = b;
            push_cmd.has_byte  = 1'b1;
            push_cmd.pair_tail = (bytes_left_reg == 8'd1) && pair_mode &&
                                 (block_code_reg > PAIR_MAX_CODE);
            bytes_left_next    = bytes_left_reg - 8'd1;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= '0;
            block_code_reg   <= '0;
            zero_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            bytes_left_reg   <= bytes_left_next;
            block_code_reg   <= block_code_next;
            zero_pending_reg <= zero_pending_next;
        end
    end

    // inside a block the code byte is never zero
    a_code_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != '0) |-> (block_code_reg != '0))
        else $error("block open with zero code byte");

    // nothing is queued while the queue is full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push)
        else $error("push while queue full");

    // a frame end leaves the block state cleared
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.frame_end) |=> (bytes_left_reg == '0 && !zero_pending_reg))
        else $error("state not cleared after frame end");

endmodule

FILE: rtl/csd_queue.sv
// Short command queue between the front end and the back end.
module csd_queue #(
    parameter int DEPTH = csd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csd_pkg::csd_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output csd_pkg::csd_cmd_t head_cmd
);
    import csd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csd_cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_ptrs_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers apart while queue empty");

endmodule

FILE: rtl/csd_back.sv
// Back end: expands queued commands into result beats behind an output register.
module csd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  csd_pkg::csd_cmd_t head_cmd,
    output logic              pop,
    csd_out_if.source         decoded
);
    import csd_pkg::*;

    csd_phase_t phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    csd_res_t   out_data_reg;
    csd_res_t   res;
    logic       load;
    logic       done;

    // free the output register when empty or when its beat leaves
    assign load = head_valid && (!out_valid_reg || decoded.ready);
    assign pop  = load && done;

    always_comb
    begin
        res        = '0;
        done       = 1'b0;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEAD:
            begin
                res.data         = head_cmd.data;
                res.has_byte     = head_cmd.has_byte;
                res.frame_end    = head_cmd.frame_end;
                res.tail_inlined = head_cmd.tail_inlined;
                res.last         = !head_cmd.pair_tail;
                done             = !head_cmd.pair_tail;
                if (load && head_cmd.pair_tail)
                    phase_next = PH_ZERO_A;
            end
            PH_ZERO_A:
            begin
                res.has_byte = 1'b1;
                if (load)
                    phase_next = PH_ZERO_B;
            end
            PH_ZERO_B:
            begin
                res.has_byte = 1'b1;
                res.last     = 1'b1;
                done         = 1'b1;
                if (load)
                    phase_next = PH_HEAD;
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (decoded.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= res;
    end

    assign decoded.valid        = out_valid_reg;
    assign decoded.out_byte     = out_data_reg.data;
    assign decoded.has_byte     = out_data_reg.has_byte;
    assign decoded.frame_end    = out_data_reg.frame_end;
    assign decoded.tail_inlined = out_data_reg.tail_inlined;
    assign decoded.last         = out_data_reg.last;

    // mid-expansion the head command stays in place and asked for the zeros
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEAD) |-> (head_valid && head_cmd.pair_tail))
        else $error("zero expansion without pair-tail command");

    a_zero_b_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ZERO_B) |-> ($past(phase_reg) == PH_ZERO_A ||
                                      $past(phase_reg) == PH_ZERO_B))
        else $error("second zero without first");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> res.last)
        else $error("command popped before its last beat");

endmodule

FILE: rtl/cobs_stream_decoder_unit.sv
// Top level of the COBS stream decoder with optional zero-pair elimination.
//
//  channel  | dir | handshake           | beat payload
//  ---------+-----+---------------------+---------------------------------------------
//  coded    | in  | valid/ready         | in_byte
//  decoded  | out | valid/ready         | out_byte, has_byte, frame_end, tail_inlined, last
//  apb      | in  | psel/penable/pready | paddr, pwdata, prdata (pair_mode at 0x0)
//
// One coded byte is accepted per cycle while the command queue has room.
// Each byte yields zero to three result beats, sent one per cycle from the
// output register while decoded is ready; a byte ending a long pair-mode block
// holds the back end for three beats; results pass the queue, then the output register.
// Reset clears block state, queue and output valid; pair_mode resets to 0.
module cobs_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = csd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    csd_in_if.sink                      coded,
    csd_out_if.source                   decoded,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csd_pkg::PADDR_W-1:0] paddr,
    input  logic [csd_pkg::DATA_W-1:0]  pwdata,
    output logic [csd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import csd_pkg::*;

    logic     pair_mode_reg;
    logic     cfg_write;
    logic     queue_full;
    logic     push;
    csd_cmd_t push_cmd;
    logic     pop;
    logic     head_valid;
    csd_cmd_t head_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[PADDR_W-1:2] == REG_PAIR_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_mode_reg <= 1'b0;
        else if (cfg_write)
            pair_mode_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_PAIR_MODE)
            prdata[0] = pair_mode_reg;
    end

    csd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_mode  (pair_mode_reg),
        .coded      (coded),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    csd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    csd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .decoded    (decoded)
    );

endmodule

FILE: dv/cobs_stream_decoder_unit_tb.sv
// Self-checking testbench for the COBS stream decoder unit.
module cobs_stream_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;

    localparam int SETTLE_CYC  = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 8;

    typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [BYTE_W-1:0] value;
        logic              typed;
        logic [1:0]        n_exp;
        csd_res_t          want;
    } stim_row_t;

    localparam csd_res_t FRAME_CLOSE = {8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam csd_res_t OWED_ZERO   = {8'h00, 1'b1, 1'b0, 1'b0, 1'b1};

    localparam int N_ROWS = 29;

    stim_row_t dir_rows [N_ROWS] = '{
        '{ROW_MODE, 8'd0,  1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, FRAME_CLOSE},
        '{ROW_BYTE, 8'h01, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'h01, 1'b1, 2'd1, OWED_ZERO},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, FRAME_CLOSE},
        '{ROW_BYTE, 8'h03, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h80, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, FRAME_CLOSE},
        '{ROW_BYTE, 8'h04, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'h01, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, csd_res_t'({8'h04, 4'b1111})},
        '{ROW_MODE, 8'd1,  1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'hE1, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'h5A, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'hFF, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, csd_res_t'({8'hFF, 4'b1111})},
        '{ROW_BYTE, 8'hE2, 1'b1, 2'd0, '0},
        '{ROW_BYTE, 8'h11, 1'b0, 2'd0, '0},
        '{ROW_MODE, 8'd0,  1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h22, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h05, 1'b0, 2'd0, '0},
        '{ROW_MODE, 8'd1,  1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, csd_res_t'({8'h05, 4'b1111})},
        '{ROW_BYTE, 8'h01, 1'b1, 2'd0, '0},
        '{ROW_MODE, 8'd0,  1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h02, 1'b1, 2'd1, OWED_ZERO},
        '{ROW_BYTE, 8'h7F, 1'b0, 2'd0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, 2'd1, FRAME_CLOSE}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    csd_in_if  coded_if ();
    csd_out_if decoded_if ();

    cobs_stream_decoder_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .coded   (coded_if),
        .decoded (decoded_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder state mirrored on the testbench side
    logic              pair_on   = 1'b0;
    logic [BYTE_W-1:0] blk_left  = '0;
    logic [BYTE_W-1:0] blk_code  = '0;
    logic              owe_zero  = 1'b0;

    csd_res_t          due_beats [$];
    logic [BYTE_W-1:0] coded_bytes [$];

    int err_cnt       = 0;
    int idle_cycles   = 0;
    int src_idle_pct  = 0;
    int rcv_stall_pct = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic csd_res_t beat(input logic [BYTE_W-1:0] d, input logic has,
                                      input logic fend, input logic tail);
        return {d, has, fend, tail, 1'b0};
    endfunction

    // Advance the mirrored state by one coded byte; return the beats it causes.
    function automatic int decode_byte(input logic [BYTE_W-1:0] b, input logic keep);
        csd_res_t          res [3];
        int                n;
        logic [BYTE_W-1:0] top_code;
        logic [BYTE_W-1:0] span;
        n = 0;
        top_code = pair_on ? PAIR_MAX_CODE : PLAIN_MAX_CODE;
        if (blk_left == 0)
        begin
            if (b == 0)
            begin
                res[n] = beat(8'h00, 1'b0, 1'b1, 1'b0);
                n++;
                blk_code = '0;
                owe_zero = 1'b0;
            end
            else
            begin
                span = (pair_on && b > PAIR_MAX_CODE) ? b - PAIR_MAX_CODE + 8'd1 : b;
                if (owe_zero)
                begin
                    res[n] = beat(8'h00, 1'b1, 1'b0, 1'b0);
                    n++;
                end
                blk_code = b;
                blk_left = span - 8'd1;
                owe_zero = (b < top_code);
            end
        end
        else if (b == 0)
        begin
            res[n] = beat(blk_code, 1'b1, 1'b1, 1'b1);
            n++;
            blk_left = '0;
            blk_code = '0;
            owe_zero = 1'b0;
        end
        else
        begin
            res[n] = beat(b, 1'b1, 1'b0, 1'b0);
            n++;
            blk_left = blk_left - 8'd1;
            // zero pair follows the last data byte of a long pair-mode block
            if (blk_left == 0 && pair_on && blk_code > PAIR_MAX_CODE)
            begin
                res[n] = beat(8'h00, 1'b1, 1'b0, 1'b0);
                n++;
                res[n] = beat(8'h00, 1'b1, 1'b0, 1'b0);
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++)
                due_beats.push_back(res[i]);
        return n;
    endfunction

    // Append one frame of coded bytes; return how many bytes it holds.
    function automatic int queue_frame(input logic with_max);
        int                r;
        int                cr;
        int                nblk;
        int                span;
        int                keep_n;
        int                added;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] top;
        added = 0;
        r = $urandom_range(99);
        top = pair_on ? PAIR_MAX_CODE : PLAIN_MAX_CODE;
        if (with_max)
        begin
            // full maximum-length block: the block after it owes no zero
            coded_bytes.push_back(top);
            repeat (int'(top) - 1)
                coded_bytes.push_back(8'($urandom_range(255, 1)));
            added = int'(top);
        end
        if (r < 8 && !with_max)
        begin
            repeat ($urandom_range(6, 1))
            begin
                coded_bytes.push_back(8'($urandom_range(255)));
                added++;
            end
        end
        else
        begin
            nblk = $urandom_range(4, 1);
            for (int k = 0; k < nblk; k++)
            begin
                cr = $urandom_range(99);
                if (pair_on && cr < 40)
                    code = 8'($urandom_range(255, 225));
                else if (cr < 80)
                    code = 8'($urandom_range(8, 1));
                else
                    code = 8'($urandom_range(40, 9));
                span = (pair_on && code > PAIR_MAX_CODE) ? int'(code - PAIR_MAX_CODE) + 1
                                                          : int'(code);
                keep_n = span - 1;
                // cut the last block short so the code byte comes back as the tail
                if (r < 22 && k == nblk - 1)
                    keep_n = $urandom_range(span - 1, 0);
                coded_bytes.push_back(code);
                added++;
                repeat (keep_n)
                begin
                    coded_bytes.push_back(8'($urandom_range(255, 1)));
                    added++;
                end
            end
        end
        coded_bytes.push_back(8'h00);
        added++;
        return added;
    endfunction

    function automatic void check_beat(input csd_res_t got);
        csd_res_t want;
        if (due_beats.size() == 0)
        begin
            $display("%0t: decoded beat %h arrived with none due", $time, got);
            err_cnt++;
        end
        else
        begin
            want = due_beats.pop_front();
            if (got.data !== want.data)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
                err_cnt++;
            end
            if (got.has_byte !== want.has_byte)
            begin
                $display("%0t: has_byte expected %b actual %b", $time, want.has_byte,
                         got.has_byte);
                err_cnt++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                         got.frame_end);
                err_cnt++;
            end
            if (got.tail_inlined !== want.tail_inlined)
            begin
                $display("%0t: tail_inlined expected %b actual %b", $time, want.tail_inlined,
                         got.tail_inlined);
                err_cnt++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                err_cnt++;
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input logic [1:0] n_exp, input csd_res_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            coded_if.valid <= 1'b0;
            @(negedge clk);
        end
        coded_if.valid   <= 1'b1;
        coded_if.in_byte <= b;
        @(posedge clk);
        while (!coded_if.ready)
            @(posedge clk);
        if (typed)
        begin
            void'(decode_byte(b, 1'b0));
            if (n_exp == 2'd1)
                due_beats.push_back(want);
        end
        else
            void'(decode_byte(b, 1'b1));
        @(negedge clk);
    endtask

    // Drain, let the block settle, then write pair_mode and read it back.
    task automatic write_mode(input logic m);
        logic [DATA_W-1:0] wd;
        wd = $urandom();
        wd[0] = m;
        coded_if.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PAIR_MODE, 2'b00};
        pwdata  <= wd;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pair_on = m;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(DATA_W-1){1'b0}}, m})
        begin
            $display("%0t: pair_mode readback expected %h actual %h", $time,
                     {{(DATA_W-1){1'b0}}, m}, prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        decoded_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            decoded_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && decoded_if.valid && decoded_if.ready)
            check_beat({decoded_if.out_byte, decoded_if.has_byte, decoded_if.frame_end,
                        decoded_if.tail_inlined, decoded_if.last});
    end

    always @(posedge clk)
    begin
        if ((coded_if.valid && coded_if.ready) || (decoded_if.valid && decoded_if.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int   phase_items;
        logic with_max;
        rst_n            = 1'b0;
        coded_if.valid   = 1'b0;
        coded_if.in_byte = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_MODE)
                write_mode(dir_rows[i].value[0]);
            else
                send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].n_exp,
                          dir_rows[i].want);
        end

        // two modes under each of the four idle patterns
        for (int p = 0; p < 8; p++)
        begin
            write_mode(p[0]);
            case (p / 2)
                0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin src_idle_pct = 57; rcv_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rcv_stall_pct = 57; end
                default: begin src_idle_pct = 25; rcv_stall_pct = 25; end
            endcase
            phase_items = 0;
            // one plain-mode maximum-length block; pair mode reaches it via long codes
            with_max = (p == 6);
            while (phase_items < PHASE_ITEMS)
            begin
                phase_items += queue_frame(with_max);
                with_max = 1'b0;
                while (coded_bytes.size() != 0)
                    send_byte(coded_bytes.pop_front(), 1'b0, 2'd0, '0);
            end
        end

        coded_if.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC)
            @(negedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
